/* rtl/ipde_pkg.sv */
// ----------------------------------------------------------------------------
// ipde_pkg
// Shared types and constants of the ir pulse-distance encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ipde_pkg;

   // field widths
   localparam int ModeW     = 3;
   localparam int IntervalW = 16;
   localparam int DataW     = 32;
   localparam int CountW    = 6;
   localparam int MsW       = 16;
   localparam int CarrierW  = 10;
   localparam int LenW      = 24;
   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 16;

   // data bits encoded by one item at most
   localparam logic [CountW-1:0] MAX_BITS = CountW'(32);

   // delay scaling: product of ms and carrier, divided by ms per second
   localparam int ProdW = MsW + CarrierW;
   localparam int QuotW = 17;
   localparam logic [CarrierW:0] MS_PER_S = (CarrierW+1)'(1000);

   // divide by 1000 as a multiply by the rounded-up reciprocal and a shift,
   // exact for every product below 2**26
   localparam int RecipW     = 27;
   localparam int RecipShift = 36;
   localparam int ScaledW    = ProdW + RecipW;
   localparam logic [RecipW-1:0] RECIP_1000 = RecipW'(68719477);

   // saturation limit of a merged interval
   localparam logic [LenW-1:0] LEN_MAX = {LenW{1'b1}};

   // input modes
   localparam logic [ModeW-1:0] MODE_MARK   = 3'd0;
   localparam logic [ModeW-1:0] MODE_SPACE  = 3'd1;
   localparam logic [ModeW-1:0] MODE_ENCODE = 3'd2;
   localparam logic [ModeW-1:0] MODE_DELAY  = 3'd3;
   localparam logic [ModeW-1:0] MODE_FINISH = 3'd4;

   // register indexes
   localparam logic [CsrIndexW-1:0] REG_CARRIER_KHZ    = 3'd0;
   localparam logic [CsrIndexW-1:0] REG_ONE_MARK_LEN   = 3'd1;
   localparam logic [CsrIndexW-1:0] REG_ONE_SPACE_LEN  = 3'd2;
   localparam logic [CsrIndexW-1:0] REG_ZERO_MARK_LEN  = 3'd3;
   localparam logic [CsrIndexW-1:0] REG_ZERO_SPACE_LEN = 3'd4;

   // register reset values
   localparam logic [CarrierW-1:0]  CARRIER_RST    = CarrierW'(38);
   localparam logic [IntervalW-1:0] ONE_MARK_RST   = IntervalW'(21);
   localparam logic [IntervalW-1:0] ONE_SPACE_RST  = IntervalW'(64);
   localparam logic [IntervalW-1:0] ZERO_MARK_RST  = IntervalW'(21);
   localparam logic [IntervalW-1:0] ZERO_SPACE_RST = IntervalW'(21);

   typedef struct packed {
      logic [ModeW-1:0]     mode;
      logic [IntervalW-1:0] interval;
      logic [DataW-1:0]     data;
      logic [CountW-1:0]    bit_count;
      logic [MsW-1:0]       delay_ms;
   } req_type;

   typedef struct packed {
      logic [LenW-1:0] duration;
      logic            is_mark;
      logic            last_of_run;
   } rsp_type;

   // operations of the merge unit
   typedef enum logic [1:0] {
      STEP_ADD,
      STEP_FINISH,
      STEP_CLOSE
   } step_kind_type;

   typedef struct packed {
      logic            valid;
      step_kind_type   kind;
      logic            mark;
      logic [LenW-1:0] len;
   } step_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_SINGLE,
      ST_MARK,
      ST_SPACE,
      ST_CLOSE
   } state_type;

endpackage

`default_nettype wire

/* rtl/ipde_div.sv */
// ----------------------------------------------------------------------------
// ipde_div
// Division of the delay product by the ms-per-second constant through a
// reciprocal multiplication, with the dividend and the quotient registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ipde_div
   import ipde_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [ProdW-1:0] dividend,
   output logic                  done,
   output logic [QuotW-1:0]      quotient
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [ProdW-1:0]   prod_ff, prod_in;
   logic [QuotW-1:0]   quo_ff, quo_in;
   logic [ScaledW-1:0] scaled;

   // multiply by the reciprocal, the quotient sits above the shift
   assign scaled = ScaledW'(prod_ff) * ScaledW'(RECIP_1000);

   always_comb begin
      busy_in = 1'b0;
      done_in = 1'b0;
      prod_in = prod_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         prod_in = dividend;
      end else if (busy_ff) begin
         done_in = 1'b1;
         quo_in  = scaled[RecipShift +: QuotW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* rtl/ipde_merge.sv */
// ----------------------------------------------------------------------------
// ipde_merge
// Pending interval with saturating merge, a one-deep hold for the last
// completed interval, and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ipde_merge
   import ipde_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire step_type step,
   output logic          step_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp_item
);

   logic            pend_valid_ff, pend_valid_in;
   logic            pend_mark_ff, pend_mark_in;
   logic [LenW-1:0] pend_len_ff, pend_len_in;
   logic            hold_valid_ff, hold_valid_in;
   logic            hold_mark_ff, hold_mark_in;
   logic [LenW-1:0] hold_len_ff, hold_len_in;
   logic            out_valid_ff, out_valid_in;
   rsp_type         out_item_ff, out_item_in;

   logic            out_free;
   logic            fire;
   logic            same;
   logic            emit;
   logic            push_mid;
   logic            push_last;
   logic [LenW:0]   sum;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign step_ready = out_free;
   assign fire       = step.valid && out_free;
   assign same       = pend_valid_ff && (pend_mark_ff == step.mark);
   assign sum        = {1'b0, pend_len_ff} + {1'b0, step.len};

   // decode of the step
   always_comb begin
      emit      = 1'b0;
      push_last = 1'b0;
      if (fire) begin
         unique case (step.kind)
            STEP_ADD:    emit = pend_valid_ff && !same;
            STEP_FINISH: emit = pend_valid_ff;
            STEP_CLOSE:  push_last = hold_valid_ff;
            default:     emit = 1'b0;
         endcase
      end
      push_mid = emit && hold_valid_ff;
   end

   // pending interval and hold
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_mark_in  = pend_mark_ff;
      pend_len_in   = pend_len_ff;
      hold_valid_in = hold_valid_ff;
      hold_mark_in  = hold_mark_ff;
      hold_len_in   = hold_len_ff;
      if (emit) begin
         hold_valid_in = 1'b1;
         hold_mark_in  = pend_mark_ff;
         hold_len_in   = pend_len_ff;
      end
      if (push_last) begin
         hold_valid_in = 1'b0;
      end
      if (fire && step.kind == STEP_ADD) begin
         if (same) begin
            pend_len_in = sum[LenW] ? LEN_MAX : sum[LenW-1:0];
         end else begin
            pend_valid_in = 1'b1;
            pend_mark_in  = step.mark;
            pend_len_in   = step.len;
         end
      end else if (fire && step.kind == STEP_FINISH) begin
         pend_valid_in = 1'b0;
         pend_mark_in  = 1'b0;
         pend_len_in   = '0;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (push_mid || push_last) begin
         out_valid_in            = 1'b1;
         out_item_in.duration    = hold_len_ff;
         out_item_in.is_mark     = hold_mark_ff;
         out_item_in.last_of_run = push_last;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_mark_ff  <= 1'b0;
         pend_len_ff   <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         pend_mark_ff  <= pend_mark_in;
         pend_len_ff   <= pend_len_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      hold_mark_ff <= hold_mark_in;
      hold_len_ff  <= hold_len_in;
      out_item_ff  <= out_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

`default_nettype wire

/* rtl/ir_pulse_distance_encoder_top.sv */
// ----------------------------------------------------------------------------
// ir_pulse_distance_encoder_top
// Builds a merged infrared mark/space duration stream from mark, space,
// encode, delay and finish items.
//
// Usage:
//   req_valid/req_ready/req_item carry one command item. req_ready is high
//   only while the sequencer is idle; one item is worked on at a time.
//   rsp_valid/rsp_ready/rsp_item carry completed intervals; the final
//   interval caused by an item has last_of_run set. An item may cause none.
//   csr_valid/csr_index/csr_data write the carrier and bit-pair lengths;
//   csr_ready is always high and writes take effect at once.
//   Each item is turned into steps that one shared merge unit applies one
//   per cycle while the result register takes them: an encode item gives a
//   mark and a space step per data bit, up to 32 bits, then a close; mark,
//   space, finish and delay, the last after forming and scaling its product,
//   give one step and a close; reserved modes, empty encodes only close.
//   A step waits while the result register is full and not taken, so a
//   stalled receiver stalls the sequencer; the next item is accepted
//   while the last result still waits.
//   Reset restores the register defaults and leaves nothing pending.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_distance_encoder_top
   import ipde_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_item,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_item,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CsrIndexW-1:0] csr_index,
   input  wire logic [CsrDataW-1:0]  csr_data
);

   state_type            state_ff, state_in;
   logic [CarrierW-1:0]  carrier_ff;
   logic [IntervalW-1:0] one_mark_ff;
   logic [IntervalW-1:0] one_space_ff;
   logic [IntervalW-1:0] zero_mark_ff;
   logic [IntervalW-1:0] zero_space_ff;
   logic [ModeW-1:0]     mode_ff, mode_in;
   logic [LenW-1:0]      len_ff, len_in;
   logic [DataW-1:0]     data_ff, data_in;
   logic [CountW-1:0]    count_ff, count_in;
   logic [MsW-1:0]       ms_ff, ms_in;

   logic                 req_fire;
   logic                 step_ready;
   step_type             step;
   logic                 div_start;
   logic                 div_done;
   logic [QuotW-1:0]     quotient;
   logic [ProdW-1:0]     product;
   logic [CountW-1:0]    count_cap;

   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign count_cap = (req_item.bit_count > MAX_BITS) ? MAX_BITS : req_item.bit_count;
   assign product   = ProdW'(ms_ff) * ProdW'(carrier_ff);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         carrier_ff    <= CARRIER_RST;
         one_mark_ff   <= ONE_MARK_RST;
         one_space_ff  <= ONE_SPACE_RST;
         zero_mark_ff  <= ZERO_MARK_RST;
         zero_space_ff <= ZERO_SPACE_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_CARRIER_KHZ:    carrier_ff    <= csr_data[CarrierW-1:0];
            REG_ONE_MARK_LEN:   one_mark_ff   <= csr_data;
            REG_ONE_SPACE_LEN:  one_space_ff  <= csr_data;
            REG_ZERO_MARK_LEN:  zero_mark_ff  <= csr_data;
            REG_ZERO_SPACE_LEN: zero_space_ff <= csr_data;
            default:            carrier_ff    <= carrier_ff;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_item.mode) inside
                  MODE_MARK, MODE_SPACE, MODE_FINISH: state_in = ST_SINGLE;
                  MODE_DELAY:  state_in = ST_MUL;
                  MODE_ENCODE: state_in = (count_cap == '0) ? ST_CLOSE : ST_MARK;
                  default:     state_in = ST_CLOSE;
               endcase
            end
         end
         ST_MUL:    state_in = ST_DIV;
         ST_DIV:    if (div_done) state_in = ST_SINGLE;
         ST_SINGLE: if (step_ready) state_in = ST_CLOSE;
         ST_MARK:   if (step_ready) state_in = ST_SPACE;
         ST_SPACE: begin
            if (step_ready) begin
               state_in = (count_ff == CountW'(1)) ? ST_CLOSE : ST_MARK;
            end
         end
         ST_CLOSE:  if (step_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready  = 1'b0;
      div_start  = 1'b0;
      step.valid = 1'b0;
      step.kind  = STEP_ADD;
      step.mark  = 1'b0;
      step.len   = len_ff;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_MUL:  div_start = 1'b1;
         ST_DIV:  step.valid = 1'b0;
         ST_SINGLE: begin
            step.valid = 1'b1;
            step.kind  = (mode_ff == MODE_FINISH) ? STEP_FINISH : STEP_ADD;
            step.mark  = (mode_ff == MODE_MARK);
         end
         ST_MARK: begin
            step.valid = 1'b1;
            step.mark  = 1'b1;
            step.len   = LenW'(data_ff[DataW-1] ? one_mark_ff : zero_mark_ff);
         end
         ST_SPACE: begin
            step.valid = 1'b1;
            step.len   = LenW'(data_ff[DataW-1] ? one_space_ff : zero_space_ff);
         end
         ST_CLOSE: begin
            step.valid = 1'b1;
            step.kind  = STEP_CLOSE;
         end
         default: req_ready = 1'b0;
      endcase
   end

   // item registers
   always_comb begin
      mode_in  = mode_ff;
      len_in   = len_ff;
      data_in  = data_ff;
      count_in = count_ff;
      ms_in    = ms_ff;
      if (req_fire) begin
         mode_in  = req_item.mode;
         len_in   = LenW'(req_item.interval);
         data_in  = req_item.data;
         count_in = count_cap;
         ms_in    = req_item.delay_ms;
      end else if (state_ff == ST_DIV && div_done) begin
         len_in = LenW'(quotient);
      end else if (state_ff == ST_SPACE && step_ready) begin
         data_in  = {data_ff[DataW-2:0], 1'b0};
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mode_ff  <= mode_in;
      len_ff   <= len_in;
      data_ff  <= data_in;
      count_ff <= count_in;
      ms_ff    <= ms_in;
   end

   // delay scaling divider
   ipde_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .done     (div_done),
      .quotient (quotient)
   );

   // shared merge unit and result register
   ipde_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .step_ready (step_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire
